### hdl/cosine_similarity_engine_defines.svh
// Assertion macros used by the checker file of the cosine similarity engine.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cse_pkg.sv
package cse_pkg;

  // Field widths.
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned COS_W   = 16;
  localparam int unsigned STS_W   = 2;

  // Accumulator, root and quotient widths.
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned NORM_W  = 32;
  localparam int unsigned DEN_W   = 64;
  localparam int unsigned REM_W   = 64;
  localparam int unsigned Q_W     = 21;
  localparam int unsigned FRAC_SH = 16;
  localparam int unsigned DIV_SH  = 31;
  localparam int unsigned DIVN_W  = ACC_W + DIV_SH;

  // Iteration counts of the shared square-root unit and of the divider.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = DIVN_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [RAD_W-1:0] SQRT_B0   = RAD_W'(1) << 62;
  localparam logic [Q_W-1:0]   Q_CLAMP   = Q_W'(1) << 20;
  localparam logic [Q_W-1:0]   Q_POS_MAX = Q_W'(32767);
  localparam logic [Q_W-1:0]   Q_NEG_MAX = Q_W'(32768);

  // Result status codes.
  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_ZERO_NORM = 2'd1;
  localparam logic [STS_W-1:0] ST_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic              accumulate;
    logic              sqrt_load;
    logic              sqrt_sel;
    logic              sqrt_step;
    logic              save_norm;
    logic              mul;
    logic              div_step;
    logic              publish;
    logic [STS_W-1:0]  pub_status;
  } cse_cmd_t;

  typedef struct packed {
    logic too_long;
    logic zero_norm;
    logic out_free;
  } cse_sts_t;

endpackage

### hdl/cse_datapath.sv
module cse_datapath import cse_pkg::*; #(
  parameter int unsigned MAX_LEN   = 1024,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ELEM_W-1:0] elem_u_i,
  input  logic [ELEM_W-1:0] elem_v_i,
  input  cse_cmd_t          cmd_i,
  output cse_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [COS_W-1:0]  cosine_o,
  output logic [STS_W-1:0]  status_o
);

  localparam int unsigned LenW = $clog2(MAX_LEN + 1);
  localparam int unsigned ProdW = 2 * ELEM_BITS;

  logic [RAW_W-1:0] raw_u, raw_v;
  logic signed [ELEM_BITS-1:0] a, b;
  logic signed [ProdW-1:0] p_ab, p_aa, p_bb;
  logic [ACC_W-1:0] ext_ab, ext_aa, ext_bb;

  logic [ACC_W-1:0] dot_q, su_q, sv_q;
  logic [LenW-1:0]  len_q;
  logic             too_long_q;

  logic [RAD_W-1:0] sq_x_q, sq_r_q, sq_b_q, sq_sum;
  logic [NORM_W-1:0] nu_q;
  logic [DEN_W-1:0] den_q, den_prod;

  logic [ACC_W-1:0]  mag;
  logic [DIVN_W-1:0] div_n_q;
  logic [REM_W-1:0]  rem_q;
  logic [REM_W:0]    rem_sh, rem_diff;
  logic [Q_W-1:0]    q_q, q_sh, q_c, q_set, q_next;
  logic              neg_q, rem_ge;

  logic [Q_W-1:0]   q_lim, q_neg;
  logic [COS_W-1:0] cos_sat;

  logic              out_valid_q;
  logic [COS_W-1:0]  cosine_q;
  logic [STS_W-1:0]  status_q;

  // Only the low ELEM_BITS bits of each element count, as two's complement.
  assign raw_u = {{(RAW_W - ELEM_W){1'b0}}, elem_u_i};
  assign raw_v = {{(RAW_W - ELEM_W){1'b0}}, elem_v_i};
  assign a     = signed'(raw_u[ELEM_BITS-1:0]);
  assign b     = signed'(raw_v[ELEM_BITS-1:0]);

  assign p_ab   = a * b;
  assign p_aa   = a * a;
  assign p_bb   = b * b;
  assign ext_ab = ACC_W'(p_ab);
  assign ext_aa = ACC_W'(p_aa);
  assign ext_bb = ACC_W'(p_bb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q      <= '0;
      su_q       <= '0;
      sv_q       <= '0;
      len_q      <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.publish) begin
      dot_q      <= '0;
      su_q       <= '0;
      sv_q       <= '0;
      len_q      <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.accumulate) begin
      if (len_q == LenW'(MAX_LEN)) begin
        too_long_q <= 1'b1;
      end else begin
        dot_q <= dot_q + ext_ab;
        su_q  <= su_q + ext_aa;
        sv_q  <= sv_q + ext_bb;
        len_q <= len_q + LenW'(1);
      end
    end
  end

  // Shared square-root unit, one result bit per cycle.
  assign sq_sum = sq_r_q + sq_b_q;

  // The norms are at most 32 bits, so one 32 by 32 product fits the denominator.
  assign den_prod = nu_q * sq_r_q[NORM_W-1:0];

  assign mag = dot_q[ACC_W-1] ? (ACC_W'(0) - dot_q) : dot_q;

  // Restoring divider; the quotient register wraps and clamps at 2^20.
  assign rem_sh   = {rem_q, div_n_q[DIVN_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});
  assign q_sh     = {q_q[Q_W-2:0], 1'b0};
  assign q_c      = q_sh[Q_W-1] ? Q_CLAMP : q_sh;
  assign q_set    = q_c | Q_W'(1);
  assign q_next   = rem_ge ? (q_set[Q_W-1] ? Q_CLAMP : q_set) : q_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      sq_x_q <= {(cmd_i.sqrt_sel ? sv_q : su_q), FRAC_SH'(0)};
      sq_r_q <= '0;
      sq_b_q <= SQRT_B0;
    end else if (cmd_i.sqrt_step) begin
      if (sq_x_q >= sq_sum) begin
        sq_x_q <= sq_x_q - sq_sum;
        sq_r_q <= (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_b_q <= sq_b_q >> 2;
    end
    if (cmd_i.save_norm) begin
      nu_q <= sq_r_q[NORM_W-1:0];
    end
    if (cmd_i.mul) begin
      den_q   <= den_prod;
      div_n_q <= {mag, DIV_SH'(0)};
      rem_q   <= '0;
      q_q     <= '0;
      neg_q   <= dot_q[ACC_W-1];
    end else if (cmd_i.div_step) begin
      div_n_q <= div_n_q << 1;
      rem_q   <= rem_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      q_q     <= q_next;
    end
  end

  // Saturation to Q1.15.
  always_comb begin
    if (neg_q) begin
      q_lim = (q_q > Q_NEG_MAX) ? Q_NEG_MAX : q_q;
    end else begin
      q_lim = (q_q > Q_POS_MAX) ? Q_POS_MAX : q_q;
    end
    q_neg   = Q_W'(0) - q_lim;
    cos_sat = neg_q ? q_neg[COS_W-1:0] : q_lim[COS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      cosine_q <= (cmd_i.pub_status == ST_OK) ? cos_sat : '0;
      status_q <= cmd_i.pub_status;
    end
  end

  assign sts_o.too_long  = too_long_q;
  assign sts_o.zero_norm = (su_q == '0) || (sv_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign cosine_o    = cosine_q;
  assign status_o    = status_q;

endmodule

### hdl/cse_controller.sv
module cse_controller import cse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     is_last_i,
  output logic     in_ready_o,
  input  cse_sts_t sts_i,
  output cse_cmd_t cmd_o
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SQU   = 3'd2;
  localparam logic [2:0] S_LDV   = 3'd3;
  localparam logic [2:0] S_SQV   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_PUB   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [STS_W-1:0] pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.pub_status = pend_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o       = 1'b1;
        cmd_o.accumulate = in_valid_i;
        if (in_valid_i && is_last_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (sts_i.too_long) begin
          pend_d  = ST_TOO_LONG;
          state_d = S_PUB;
        end else if (sts_i.zero_norm) begin
          pend_d  = ST_ZERO_NORM;
          state_d = S_PUB;
        end else begin
          pend_d          = ST_OK;
          cmd_o.sqrt_load = 1'b1;
          state_d         = S_SQU;
        end
      end
      S_SQU: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_LDV;
        end
      end
      S_LDV: begin
        cmd_o.save_norm = 1'b1;
        cmd_o.sqrt_load = 1'b1;
        cmd_o.sqrt_sel  = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQV;
      end
      S_SQV: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_PUB;
        end
      end
      S_PUB: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
      pend_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### hdl/cosine_similarity_engine.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    elem_u_i, elem_v_i, is_last_i
// result    out        out_valid_o / out_ready_i  cosine_o, status_o
//
// One element pair is taken per cycle while a vector streams in. After the transfer of
// the last pair the input is held off for one check, two passes of 32 iterations on the
// shared square-root unit, one handover, one multiply, 79 divider steps and the load of
// the output register; a too-long vector or a zero norm goes from the check to that load.
// Reset is asynchronous and active low and clears the sums, count and output valid flag.
// The output register lets the next vector stream in while a result waits for its transfer.
module cosine_similarity_engine import cse_pkg::*; #(
  parameter int unsigned MAX_LEN   = 1024,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ELEM_W-1:0] elem_u_i,
  input  logic [ELEM_W-1:0] elem_v_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [COS_W-1:0]  cosine_o,
  output logic [STS_W-1:0]  status_o
);

  // The controller sequences the square roots, the multiply and the divide;
  // the datapath owns every accumulator and arithmetic unit.
  cse_cmd_t cmd;
  cse_sts_t sts;

  cse_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_last_i  (is_last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Each element pair is accumulated in the cycle of its transfer, so the sums are
  // complete when the controller leaves the accumulate state.
  cse_datapath #(
    .MAX_LEN   (MAX_LEN),
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_u_i    (elem_u_i),
    .elem_v_i    (elem_v_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cosine_o    (cosine_o),
    .status_o    (status_o)
  );

endmodule

### hdl/cse_checker.sv
`include "cosine_similarity_engine_defines.svh"

module cse_checker import cse_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              is_last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [COS_W-1:0]  cosine_o,
  input logic [STS_W-1:0]  status_o
);

  logic                     out_stall;
  logic [COS_W+STS_W-1:0]   out_payload;
  logic                     status_legal;
  logic                     fault_shown;
  logic                     last_xfer;

  assign out_stall    = out_valid_o && !out_ready_i;
  assign out_payload  = {cosine_o, status_o};
  assign status_legal = (status_o == ST_OK) || (status_o == ST_ZERO_NORM) ||
                        (status_o == ST_TOO_LONG);
  assign fault_shown  = out_valid_o && (status_o != ST_OK);
  assign last_xfer    = in_valid_i && in_ready_o && is_last_i;

  `CSE_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_payload), "result not held")

  `CSE_ASSERT_NOW(a_status_legal, out_valid_o, status_legal, "illegal status code")

  `CSE_ASSERT_NOW(a_fault_zero, fault_shown, cosine_o == '0, "cosine not zero on a fault")

  `CSE_ASSERT_NEXT(a_last_blocks, last_xfer, !in_ready_o, "input taken during evaluation")

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (.*);
